>>> src/sgr_pkg.sv
// shared types, constants and the 5x7 font table of the glyph row rasteriser
// no dependencies

package sgr_pkg;

  localparam int MAX_CHARS    = 32;
  localparam int ROW_PIXELS   = 400;
  localparam int ROW_BYTES    = 50;
  localparam int MAX_SCALE    = 8;
  localparam int SLOT_W       = $clog2(MAX_CHARS);
  localparam int PIX_PER_BYTE = 8;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 7;
  localparam int CELL_COLS    = 6;

  // shared divider: 9-bit dividend, divisor up to 6 * MAX_SCALE
  localparam int DIV_W     = 9;
  localparam int DVSR_W    = 6;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_SCALE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INK_SETS    = 3'd4;

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef struct packed {
    logic [8:0] origin_x;
    logic [8:0] origin_y;
    logic [3:0] text_scale;
    logic [5:0] text_length;
    logic       ink_sets_bit;
  } sgr_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [DVSR_W-1:0] remainder;
  } div_rsp_t;

  // five column bytes, leftmost column in the top byte, bit 0 is the top glyph row
  function automatic logic [39:0] font_cols(input logic [7:0] code);
    logic [39:0] g;
    begin
      case (code)
        8'h2D: g = 40'h00_00_7E_00_00;
        8'h2E: g = 40'h00_00_40_00_00;
        8'h3A: g = 40'h00_36_00_36_00;
        8'h2F: g = 40'h08_08_14_22_41;
        8'h25: g = 40'h62_14_08_14_46;
        8'h30: g = 40'h3E_51_49_45_3E;
        8'h31: g = 40'h00_42_7F_40_00;
        8'h32: g = 40'h62_51_49_49_46;
        8'h33: g = 40'h22_49_49_49_36;
        8'h34: g = 40'h18_14_12_7F_10;
        8'h35: g = 40'h2F_49_49_49_31;
        8'h36: g = 40'h3E_49_49_49_32;
        8'h37: g = 40'h01_71_09_05_03;
        8'h38: g = 40'h36_49_49_49_36;
        8'h39: g = 40'h26_49_49_49_3E;
        8'h41: g = 40'h7E_11_11_11_7E;
        8'h42: g = 40'h7F_49_49_49_36;
        8'h43: g = 40'h3E_41_41_41_22;
        8'h44: g = 40'h7F_41_41_22_1C;
        8'h45: g = 40'h7F_49_49_49_41;
        8'h46: g = 40'h7F_09_09_09_01;
        8'h47: g = 40'h3E_41_49_49_7A;
        8'h48: g = 40'h7F_08_08_08_7F;
        8'h49: g = 40'h00_41_7F_41_00;
        8'h4A: g = 40'h20_40_41_3F_01;
        8'h4B: g = 40'h7F_08_14_22_41;
        8'h4C: g = 40'h7F_40_40_40_40;
        8'h4D: g = 40'h7F_02_0C_02_7F;
        8'h4E: g = 40'h7F_02_0C_10_7F;
        8'h4F: g = 40'h3E_41_41_41_3E;
        8'h50: g = 40'h7F_09_09_09_06;
        8'h51: g = 40'h3E_41_51_21_5E;
        8'h52: g = 40'h7F_09_19_29_46;
        8'h53: g = 40'h26_49_49_49_32;
        8'h54: g = 40'h01_01_7F_01_01;
        8'h55: g = 40'h3F_40_40_40_3F;
        8'h56: g = 40'h0F_30_40_30_0F;
        8'h57: g = 40'h3F_40_38_40_3F;
        8'h58: g = 40'h63_14_08_14_63;
        8'h59: g = 40'h07_08_70_08_07;
        8'h5A: g = 40'h61_51_49_45_43;
        8'h61: g = 40'h20_54_54_54_78;
        8'h62: g = 40'h7F_48_44_44_38;
        8'h63: g = 40'h38_44_44_44_20;
        8'h64: g = 40'h38_44_44_48_7F;
        8'h65: g = 40'h38_54_54_54_18;
        8'h66: g = 40'h08_7E_09_01_02;
        8'h67: g = 40'h0C_52_52_52_3E;
        8'h68: g = 40'h7F_08_04_04_78;
        8'h69: g = 40'h00_44_7D_40_00;
        8'h6A: g = 40'h20_40_44_3D_00;
        8'h6B: g = 40'h7F_10_28_44_00;
        8'h6C: g = 40'h00_41_7F_40_00;
        8'h6D: g = 40'h7C_04_18_04_78;
        8'h6E: g = 40'h7C_08_04_04_78;
        8'h6F: g = 40'h38_44_44_44_38;
        8'h70: g = 40'h7C_14_14_14_08;
        8'h71: g = 40'h08_14_14_18_7C;
        8'h72: g = 40'h7C_08_04_04_08;
        8'h73: g = 40'h48_54_54_54_20;
        8'h74: g = 40'h04_3F_44_40_20;
        8'h75: g = 40'h3C_40_40_20_7C;
        8'h76: g = 40'h1C_20_40_20_1C;
        8'h77: g = 40'h3C_40_30_40_3C;
        8'h78: g = 40'h44_28_10_28_44;
        8'h79: g = 40'h0C_50_50_50_3C;
        8'h7A: g = 40'h44_64_54_4C_44;
        default: g = '0;
      endcase
      return g;
    end
  endfunction

  function automatic logic glyph_bit(input logic [7:0] code, input logic [2:0] col,
                                     input logic [2:0] row);
    logic [39:0] cols;
    logic [7:0]  colbits;
    begin
      cols = font_cols(code);
      case (col)
        3'd0: colbits = cols[39:32];
        3'd1: colbits = cols[31:24];
        3'd2: colbits = cols[23:16];
        3'd3: colbits = cols[15:8];
        3'd4: colbits = cols[7:0];
        default: colbits = '0;
      endcase
      return colbits[row];
    end
  endfunction

endpackage

>>> src/sgr_if.sv
// request and response channels of the glyph row rasteriser
// depends on sgr_pkg

interface sgr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [sgr_pkg::SLOT_W-1:0] char_slot;
  logic [7:0]                char_code;
  logic [8:0]                row_y;
  logic [5:0]                byte_column;

  modport source (output valid, action, char_slot, char_code, row_y, byte_column,
                  input ready);
  modport sink (input valid, action, char_slot, char_code, row_y, byte_column,
                output ready);
endinterface

interface sgr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_byte;

  modport source (output valid, row_byte, input ready);
  modport sink (input valid, row_byte, output ready);
endinterface

>>> src/sgr_apb_regs.sv
// apb configuration registers: origin, scale, text length, ink polarity
// depends on sgr_pkg

module sgr_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sgr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sgr_pkg::sgr_cfg_t                cfg
);
  import sgr_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.text_scale   <= 4'd1;
      cfg.text_length  <= '0;
      cfg.ink_sets_bit <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_ORIGIN_X:    cfg.origin_x     <= pwdata[8:0];
        REG_ORIGIN_Y:    cfg.origin_y     <= pwdata[8:0];
        REG_TEXT_SCALE:  cfg.text_scale   <= pwdata[3:0];
        REG_TEXT_LENGTH: cfg.text_length  <= pwdata[5:0];
        REG_INK_SETS:    cfg.ink_sets_bit <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:    prdata = {23'd0, cfg.origin_x};
      REG_ORIGIN_Y:    prdata = {23'd0, cfg.origin_y};
      REG_TEXT_SCALE:  prdata = {28'd0, cfg.text_scale};
      REG_TEXT_LENGTH: prdata = {26'd0, cfg.text_length};
      REG_INK_SETS:    prdata = {31'd0, cfg.ink_sets_bit};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> src/sgr_div_unit.sv
// shared restoring divider, one quotient bit per cycle
// depends on sgr_pkg

module sgr_div_unit (
  input  logic              clk,
  input  logic              rst,
  input  sgr_pkg::div_req_t div_req,
  output sgr_pkg::div_rsp_t div_rsp
);
  import sgr_pkg::*;

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVSR_W-1:0]    rem;
  logic [DIV_W-1:0]     quo;
  logic [DVSR_W-1:0]    dvsr;
  logic [DVSR_W:0]      trial;
  logic [DVSR_W:0]      diff;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem  <= '0;
      quo  <= div_req.dividend;
      dvsr <= div_req.divisor;
    end else if (run) begin
      rem <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign div_rsp.busy      = run;
  assign div_rsp.done      = done;
  assign div_rsp.quotient  = quo;
  assign div_rsp.remainder = rem;

endmodule

>>> src/sgr_text_store.sv
// character code store, one write and one registered read port
// depends on sgr_pkg

module sgr_text_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sgr_pkg::SLOT_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [sgr_pkg::SLOT_W-1:0] raddr,
  output logic [7:0]                 rdata
);
  import sgr_pkg::*;

  logic [7:0] mem [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/scaled_glyph_row_rasterizer.sv
// glyph row rasteriser top level: sequencer, pixel walk and output register
// depends on sgr_pkg, sgr_if, sgr_apb_regs, sgr_div_unit, sgr_text_store
// store request: written to the text store on acceptance, no response; the next request may follow at once
// render request: the byte is presented once the output slot is free, and no new request is taken before then;
//   three passes through the shared divider, then a pixel walk and drain
// reset clears the sequencer, output valid and config registers (scale 1), not the text store

module scaled_glyph_row_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  sgr_req_if.sink                        req,
  sgr_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sgr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sgr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sgr_pkg::*;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_DIV_Y = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV_X = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV_C = 3'd3;
  localparam logic [ST_W-1:0] ST_WALK  = 3'd4;
  localparam logic [ST_W-1:0] ST_DRAIN = 3'd5;
  localparam logic [ST_W-1:0] ST_OUT   = 3'd6;

  sgr_cfg_t cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [ST_W-1:0] state;
  logic [8:0]      x0;
  logic [8:0]      d0;
  logic [3:0]      lead;
  logic            dy_ok;
  logic            col_ok;
  logic [2:0]      gy;
  logic            row_ok;
  logic [6:0]      ci;
  logic [2:0]      col;
  logic [2:0]      sub;
  logic [2:0]      pix;
  logic            p_valid;
  logic            p_elig;
  logic [2:0]      p_col;
  logic [7:0]      acc;
  logic            out_valid;
  logic [7:0]      out_byte;
  logic [7:0]      mem_q;

  logic [3:0] s;
  logic [5:0] len;
  logic [5:0] six_s;
  logic       req_fire;
  logic       render_go;
  logic       store_go;
  logic [8:0] x0_in;
  logic [8:0] dy_in;
  logic [8:0] gap_in;
  logic       active;
  logic [9:0] x_pix;
  logic       elig;
  logic       slot_free;

  sgr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgr_div_unit u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  sgr_text_store u_store (
    .clk   (clk),
    .we    (store_go),
    .waddr (req.char_slot),
    .wdata (req.char_code),
    .raddr (ci[SLOT_W-1:0]),
    .rdata (mem_q)
  );

  assign s     = (cfg.text_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : cfg.text_scale;
  assign len   = (cfg.text_length > 6'(MAX_CHARS)) ? 6'(MAX_CHARS) : cfg.text_length;
  assign six_s = {s, 2'b00} + {1'b0, s, 1'b0};

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid & req.ready;
  assign render_go = req_fire && (req.action == ACT_RENDER);
  assign store_go  = req_fire && (req.action == ACT_STORE);

  assign x0_in  = {req.byte_column, 3'b000};
  assign dy_in  = req.row_y - cfg.origin_y;
  assign gap_in = cfg.origin_x - x0_in;

  assign active = {1'b0, pix} >= lead;
  assign x_pix  = {1'b0, x0} + {7'd0, pix};
  assign elig   = row_ok && active && col_ok && (x_pix < 10'(ROW_PIXELS))
                  && (ci < {1'b0, len}) && (col < 3'(GLYPH_COLS));

  assign slot_free = !out_valid || rsp.ready;

  // divider operand selection per pass
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      ST_IDLE: begin
        div_req.start    = render_go;
        div_req.dividend = dy_in;
        div_req.divisor  = {2'b00, s};
      end
      ST_DIV_Y: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = d0;
        div_req.divisor  = six_s;
      end
      ST_DIV_X: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {3'd0, div_rsp.remainder};
        div_req.divisor  = {2'b00, s};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      p_valid <= (state == ST_WALK);
      if (state == ST_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (render_go) state <= ST_DIV_Y;
        ST_DIV_Y: if (div_rsp.done) state <= ST_DIV_X;
        ST_DIV_X: if (div_rsp.done) state <= ST_DIV_C;
        ST_DIV_C: if (div_rsp.done) state <= ST_WALK;
        ST_WALK:  if (pix == 3'(PIX_PER_BYTE - 1)) state <= ST_DRAIN;
        ST_DRAIN: state <= ST_OUT;
        ST_OUT:   if (slot_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // position tracking and pixel walk
  always_ff @(posedge clk) begin
    if (render_go) begin
      x0     <= x0_in;
      dy_ok  <= req.row_y >= cfg.origin_y;
      col_ok <= req.byte_column < 6'(ROW_BYTES);
      if (x0_in >= cfg.origin_x) begin
        lead <= '0;
        d0   <= x0_in - cfg.origin_x;
      end else begin
        lead <= (gap_in >= 9'(PIX_PER_BYTE)) ? 4'(PIX_PER_BYTE) : gap_in[3:0];
        d0   <= '0;
      end
    end
    if (state == ST_DIV_Y && div_rsp.done) begin
      gy     <= div_rsp.quotient[2:0];
      row_ok <= dy_ok && (div_rsp.quotient < 9'(GLYPH_ROWS)) && (s != 4'd0);
    end
    if (state == ST_DIV_X && div_rsp.done) begin
      ci <= div_rsp.quotient[6:0];
    end
    if (state == ST_DIV_C && div_rsp.done) begin
      col <= div_rsp.quotient[2:0];
      sub <= div_rsp.remainder[2:0];
      pix <= '0;
    end
    if (state == ST_WALK) begin
      p_elig <= elig;
      p_col  <= col;
      pix    <= pix + 3'd1;
      if (active) begin
        if ({1'b0, sub} + 4'd1 == s) begin
          sub <= '0;
          if (col == 3'(CELL_COLS - 1)) begin
            col <= '0;
            ci  <= ci + 7'd1;
          end else begin
            col <= col + 3'd1;
          end
        end else begin
          sub <= sub + 3'd1;
        end
      end
    end
    // glyph lookup in the cycle after each walk step, after the store read
    if (p_valid) begin
      acc <= {acc[6:0], p_elig && glyph_bit(mem_q, p_col, gy)};
    end
    if (state == ST_OUT && slot_free) begin
      out_byte <= cfg.ink_sets_bit ? acc : ~acc;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.row_byte = out_byte;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_Y || state == ST_DIV_X || state == ST_DIV_C))
    else $error("divider result outside a division pass");

  a_col_in_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_C && div_rsp.done && s != 4'd0) |-> div_rsp.quotient < 9'(CELL_COLS))
    else $error("glyph column beyond cell width");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("pixel pipeline active outside the walk");

  a_out_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> $past(state == ST_DRAIN) || $past(state == ST_OUT))
    else $error("output state entered without drain");

endmodule

>>> tb/testbench.sv
// self-checking bench for the glyph row rasteriser: directed and random requests
// with an own pixel predictor, checked result by result under random idling
// depends on sgr_pkg, sgr_if and scaled_glyph_row_rasterizer

module testbench;
  import sgr_pkg::*;

  typedef struct {
    logic       action;
    logic [4:0] slot;
    logic [7:0] code;
    logic [8:0] row_y;
    logic [5:0] bcol;
  } text_request_t;

  localparam string FONT_CHARS =
    " -.:/%0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sgr_req_if req_bus();
  sgr_rsp_if rsp_bus();

  scaled_glyph_row_rasterizer u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // layout copy and text copy used for prediction
  logic [8:0] lay_origin_x;
  logic [8:0] lay_origin_y;
  logic [3:0] lay_scale;
  logic [5:0] lay_length;
  logic       lay_ink_sets;
  logic [7:0] text_copy [MAX_CHARS];

  logic [7:0] pending_row_bytes [$];
  int         error_count;
  int         sender_idle_pct;
  int         receiver_stall_pct;
  int         hold_off_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [0:4][7:0] glyph_columns(input logic [7:0] code);
    logic [0:4][7:0] g;
    begin
      case (code)
        8'h2D: g = {8'h00, 8'h00, 8'h7E, 8'h00, 8'h00};
        8'h2E: g = {8'h00, 8'h00, 8'h40, 8'h00, 8'h00};
        8'h3A: g = {8'h00, 8'h36, 8'h00, 8'h36, 8'h00};
        8'h2F: g = {8'h08, 8'h08, 8'h14, 8'h22, 8'h41};
        8'h25: g = {8'h62, 8'h14, 8'h08, 8'h14, 8'h46};
        8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
        8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
        8'h32: g = {8'h62, 8'h51, 8'h49, 8'h49, 8'h46};
        8'h33: g = {8'h22, 8'h49, 8'h49, 8'h49, 8'h36};
        8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
        8'h35: g = {8'h2F, 8'h49, 8'h49, 8'h49, 8'h31};
        8'h36: g = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h32};
        8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
        8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
        8'h39: g = {8'h26, 8'h49, 8'h49, 8'h49, 8'h3E};
        8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
        8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
        8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
        8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
        8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
        8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
        8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
        8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
        8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
        8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
        8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
        8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
        8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
        8'h4E: g = {8'h7F, 8'h02, 8'h0C, 8'h10, 8'h7F};
        8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
        8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
        8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
        8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
        8'h53: g = {8'h26, 8'h49, 8'h49, 8'h49, 8'h32};
        8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
        8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
        8'h56: g = {8'h0F, 8'h30, 8'h40, 8'h30, 8'h0F};
        8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
        8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
        8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
        8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
        8'h61: g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
        8'h62: g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
        8'h63: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
        8'h64: g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
        8'h65: g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
        8'h66: g = {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
        8'h67: g = {8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E};
        8'h68: g = {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
        8'h69: g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
        8'h6A: g = {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
        8'h6B: g = {8'h7F, 8'h10, 8'h28, 8'h44, 8'h00};
        8'h6C: g = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
        8'h6D: g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
        8'h6E: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
        8'h6F: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
        8'h70: g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
        8'h71: g = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
        8'h72: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
        8'h73: g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
        8'h74: g = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
        8'h75: g = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
        8'h76: g = {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
        8'h77: g = {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
        8'h78: g = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
        8'h79: g = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
        8'h7A: g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
        default: g = '0;
      endcase
      return g;
    end
  endfunction

  function automatic logic [7:0] predict_row_byte(input logic [8:0] y, input logic [5:0] bcol);
    int              s;
    int              len;
    int              b;
    int              x;
    int              d;
    int              gy;
    int              ci;
    int              col;
    logic            inked;
    logic [0:4][7:0] g;
    logic [7:0]      col_bits;
    logic [7:0]      pix;
    begin
      s   = (lay_scale > MAX_SCALE) ? MAX_SCALE : int'(lay_scale);
      len = (lay_length > MAX_CHARS) ? MAX_CHARS : int'(lay_length);
      pix = lay_ink_sets ? 8'h00 : 8'hFF;
      for (b = 0; b < 8; b = b + 1) begin
        x     = int'(bcol) * 8 + b;
        inked = 1'b0;
        if (s != 0 && x < ROW_PIXELS && x >= int'(lay_origin_x) && int'(y) >= int'(lay_origin_y)) begin
          gy  = (int'(y) - int'(lay_origin_y)) / s;
          d   = x - int'(lay_origin_x);
          ci  = d / (6 * s);
          col = (d % (6 * s)) / s;
          if (gy < 7 && ci < len && col < 5) begin
            g        = glyph_columns(text_copy[ci]);
            col_bits = g[col];
            inked    = col_bits[gy];
          end
        end
        if (inked) begin
          pix[7-b] = lay_ink_sets;
        end
      end
      return pix;
    end
  endfunction

  // request and response monitor
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        if (req_bus.action == ACT_RENDER) begin
          pending_row_bytes.push_back(predict_row_byte(req_bus.row_y, req_bus.byte_column));
        end else begin
          text_copy[req_bus.char_slot] = req_bus.char_code;
        end
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_row_bytes.size() == 0) begin
          $error("row_byte %02h arrived with no render outstanding", rsp_bus.row_byte);
          error_count++;
        end else begin
          want = pending_row_bytes.pop_front();
          if (rsp_bus.row_byte !== want) begin
            $error("row_byte mismatch: expected %02h, got %02h", want, rsp_bus.row_byte);
            error_count++;
          end
        end
      end
    end
  end

  // receiver back-pressure, with a counted hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_item(input text_request_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.action      <= it.action;
    req_bus.char_slot   <= it.slot;
    req_bus.char_code   <= it.code;
    req_bus.row_y       <= it.row_y;
    req_bus.byte_column <= it.bcol;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_row_bytes.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic store_char(input logic [4:0] slot, input logic [7:0] code);
    text_request_t it;
    it.action = ACT_STORE;
    it.slot   = slot;
    it.code   = code;
    it.row_y  = 9'($urandom);
    it.bcol   = 6'($urandom);
    send_item(it);
  endtask

  task automatic render_byte(input logic [8:0] y, input logic [5:0] bcol);
    text_request_t it;
    it.action = ACT_RENDER;
    it.slot   = 5'($urandom);
    it.code   = 8'($urandom);
    it.row_y  = y;
    it.bcol   = bcol;
    send_item(it);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:    lay_origin_x = value[8:0];
      REG_ORIGIN_Y:    lay_origin_y = value[8:0];
      REG_TEXT_SCALE:  lay_scale    = value[3:0];
      REG_TEXT_LENGTH: lay_length   = value[5:0];
      REG_INK_SETS:    lay_ink_sets = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_layout(input int ox, input int oy, input int scale, input int len,
                            input int ink);
    end_burst();
    wait_drained();
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_TEXT_SCALE, 32'(scale));
    write_reg(REG_TEXT_LENGTH, 32'(len));
    write_reg(REG_INK_SETS, 32'(ink));
  endtask

  function automatic logic [7:0] random_code();
    if ($urandom_range(9) < 7) begin
      return FONT_CHARS[$urandom_range(FONT_CHARS.len() - 1)];
    end
    return 8'($urandom_range(255));
  endfunction

  // mostly aimed at the text area, the rest anywhere the fields reach
  task automatic random_request();
    int s;
    int len;
    int y;
    int bc;
    if ($urandom_range(99) < 30) begin
      store_char(5'($urandom_range(31)), random_code());
    end else begin
      s   = (lay_scale > MAX_SCALE) ? MAX_SCALE : int'(lay_scale);
      len = (lay_length > MAX_CHARS) ? MAX_CHARS : int'(lay_length);
      if ($urandom_range(99) < 80) begin
        y  = int'(lay_origin_y) + $urandom_range(7 * s + 1);
        bc = int'(lay_origin_x) / 8 + $urandom_range(len * 6 * s / 8 + 1);
        if (y > 511) y = $urandom_range(511);
        if (bc > 63) bc = $urandom_range(63);
      end else begin
        y  = $urandom_range(511);
        bc = $urandom_range(63);
      end
      render_byte(9'(y), 6'(bc));
    end
  endtask

  task automatic test_text_load();
    string text;
    int    i;
    text = "0123456789ABCDEF-.:/%az XQRmwg!~";
    // text length still zero, so the unwritten store contents are never used
    render_byte(9'd0, 6'd0);
    for (i = 0; i < MAX_CHARS; i++) begin
      store_char(5'(i), text[i]);
    end
    end_burst();
  endtask

  task automatic test_directed();
    set_layout(0, 0, 1, 32, 0);
    render_byte(9'd0, 6'd0);
    render_byte(9'd3, 6'd2);
    render_byte(9'd6, 6'd23);
    render_byte(9'd7, 6'd0);
    render_byte(9'd511, 6'd63);
    render_byte(9'd1, 6'd24);
    // unknown codes, lowest and highest
    store_char(5'd0, 8'h00);
    store_char(5'd1, 8'hFF);
    render_byte(9'd2, 6'd0);
    store_char(5'd0, "W");
    store_char(5'd1, "%");
    set_layout(399, 299, 15, 63, 1);
    render_byte(9'd299, 6'd49);
    render_byte(9'd300, 6'd49);
    render_byte(9'd305, 6'd50);
    set_layout(3, 5, 8, 63, 1);
    render_byte(9'd20, 6'd0);
    render_byte(9'd60, 6'd47);
    render_byte(9'd61, 6'd5);
    set_layout(0, 0, 0, 32, 0);
    render_byte(9'd0, 6'd0);
    set_layout(511, 511, 1, 32, 1);
    render_byte(9'd511, 6'd63);
    render_byte(9'd511, 6'd49);
    end_burst();
  endtask

  task automatic test_random();
    int p;
    int n;
    int ox;
    int oy;
    int sc;
    int len;
    int r;
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
      r   = $urandom_range(19);
      sc  = (r == 0) ? 0 : (r == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1);
      len = ($urandom_range(9) == 0) ? $urandom_range(63, 33) : $urandom_range(32);
      ox  = ($urandom_range(9) == 0) ? $urandom_range(511, 400) :
            ($urandom_range(1) == 0) ? $urandom_range(120) : $urandom_range(399);
      oy  = ($urandom_range(9) == 0) ? $urandom_range(511, 300) : $urandom_range(299);
      set_layout(ox, oy, sc, len, $urandom_range(1));
      for (n = 0; n < 45; n++) begin
        random_request();
      end
      end_burst();
    end
  endtask

  task automatic test_backpressure();
    int n;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    set_layout(10, 20, 2, 32, 0);
    hold_off_left = 400;
    for (n = 0; n < 10; n++) begin
      render_byte(9'(20 + $urandom_range(14)), 6'($urandom_range(2, 35)));
    end
    end_burst();
  endtask

  task automatic test_sender_pause();
    int n;
    sender_idle_pct    = 22;
    receiver_stall_pct = 22;
    for (n = 0; n < 10; n++) begin
      random_request();
    end
    end_burst();
    while (pending_row_bytes.size() != 0) @(posedge clk);
    for (n = 0; n < 10; n++) begin
      random_request();
    end
    end_burst();
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_bus.valid       = 1'b0;
    req_bus.action      = ACT_STORE;
    req_bus.char_slot   = '0;
    req_bus.char_code   = '0;
    req_bus.row_y       = '0;
    req_bus.byte_column = '0;
    rsp_bus.ready       = 1'b0;
    error_count         = 0;
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    hold_off_left       = 0;
    lay_origin_x        = '0;
    lay_origin_y        = '0;
    lay_scale           = 4'd1;
    lay_length          = '0;
    lay_ink_sets        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_text_load();
    test_directed();
    test_random();
    test_backpressure();
    test_sender_pause();

    wait_drained();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/sgr_pkg.sv
src/sgr_if.sv
src/sgr_apb_regs.sv
src/sgr_div_unit.sv
src/sgr_text_store.sv
src/scaled_glyph_row_rasterizer.sv
tb/testbench.sv
